// ----- src/tocq_pkg.sv -----
`timescale 1ns / 1ps
// tocq_pkg: shared types and codes for the time ordered command queue
// used by tocq_cell and time_ordered_command_queue; no dependencies
package tocq_pkg;

  // command kinds carried in s_axis_tuser
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_POP    = 2'd2;

  // result status carried in m_axis_tuser
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int ID_W   = 16;
  localparam int TKEY_W = 32;
  localparam int OCC_W  = 5;

  // one stored entry without its payload
  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [TKEY_W-1:0] tkey;
  } tocq_entry_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic              ins;
    logic              pop;
    logic              ordered;
    logic [ID_W-1:0]   id;
    logic [TKEY_W-1:0] tkey;
  } tocq_ctl_t;

endpackage

// ----- src/tocq_cell.sv -----
`timescale 1ns / 1ps
// tocq_cell: one slot of the queue, holding an entry and its payload
// depends on tocq_pkg
module tocq_cell
  import tocq_pkg::*;
#(
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tocq_ctl_t                ctl,
  input  logic [PAYLOAD_WIDTH-1:0] new_pl,
  input  tocq_entry_t              left_ent,
  input  logic [PAYLOAD_WIDTH-1:0] left_pl,
  input  tocq_entry_t              right_ent,
  input  logic [PAYLOAD_WIDTH-1:0] right_pl,
  input  logic                     before_in,
  output logic                     before_out,
  output tocq_entry_t              ent,
  output logic [PAYLOAD_WIDTH-1:0] pl,
  output tocq_entry_t              ent_next
);

  logic                     place;
  logic [PAYLOAD_WIDTH-1:0] pl_next;

  // an empty slot, or a later time on an ordered insert, marks the insert point
  assign place      = !ent.valid || (ctl.ordered && (ent.tkey > ctl.tkey));
  assign before_out = before_in || place;

  // shift towards the tail on insert, towards the head on pop
  always_comb begin
    ent_next = ent;
    pl_next  = pl;
    if (ctl.ins) begin
      if (before_in) begin
        ent_next = left_ent;
        pl_next  = left_pl;
      end else if (place) begin
        ent_next = '{valid: 1'b1, id: ctl.id, tkey: ctl.tkey};
        pl_next  = new_pl;
      end
    end else if (ctl.pop) begin
      ent_next = right_ent;
      pl_next  = right_pl;
    end
  end

  // entry register, only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent.valid <= ent_next.valid;
    end
    ent.id   <= ent_next.id;
    ent.tkey <= ent_next.tkey;
    pl       <= pl_next;
  end

endmodule

// ----- src/time_ordered_command_queue.sv -----
`timescale 1ns / 1ps
// time_ordered_command_queue: bounded time ordered queue built as a row of cells
// depends on tocq_pkg and tocq_cell
//
// Takes one beat per clock and returns one result beat for each through an
// output register; a new beat is taken while the previous result waits as
// long as the result register is free or being read. The whole insert or
// pop is done in the same cycle as the beat is taken, by the row of QUEUE_DEPTH
// cells: every cell compares its time key with the new one, the insert point
// ripples along the row from the head, and each cell loads its own entry,
// its neighbour's or the new one. That ripple sets the critical path, which
// grows linearly with QUEUE_DEPTH. An ordered insert goes behind every entry
// with an equal or earlier time; an append goes to the tail. An insert into
// a full queue and a pop of an empty queue change nothing and are flagged in
// the status. Payloads are stored at PAYLOAD_WIDTH bits.
module time_ordered_command_queue
  import tocq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // entry_id[15:0], entry_time[47:16], cmd_payload[79:48]
  input  logic [79:0]  s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // popped_id[15:0], popped_time[47:16], popped_payload[79:48], head_valid[80],
  // head_id[96:81], occupancy[101:97], zero[103:102]
  output logic [103:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]   m_axis_tuser
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  // input unpacking
  logic [1:0]        kind;
  logic [ID_W-1:0]   in_id;
  logic [TKEY_W-1:0] in_tkey;
  logic [31:0]       in_pl;
  logic [PAYLOAD_WIDTH+31:0] in_pl_ext;
  logic [PAYLOAD_WIDTH-1:0]  new_pl;

  assign kind      = s_axis_tuser;
  assign in_id     = s_axis_tdata[15:0];
  assign in_tkey   = s_axis_tdata[47:16];
  assign in_pl     = s_axis_tdata[79:48];
  assign in_pl_ext = {{PAYLOAD_WIDTH{1'b0}}, in_pl};
  assign new_pl    = in_pl_ext[PAYLOAD_WIDTH-1:0];

  logic accept;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic is_ins;
  logic is_pop;
  logic full;
  logic empty;
  tocq_ctl_t ctl;
  logic [1:0] status_next;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count == DEPTH_C);
  assign empty         = (count == '0);
  assign is_ins        = (kind == KIND_INSERT) || (kind == KIND_APPEND);
  assign is_pop        = (kind == KIND_POP);

  // broadcast operation
  always_comb begin
    ctl.ins     = accept && is_ins && !full;
    ctl.pop     = accept && is_pop && !empty;
    ctl.ordered = (kind == KIND_INSERT);
    ctl.id      = in_id;
    ctl.tkey    = in_tkey;
  end

  // status and count update
  always_comb begin
    status_next = ST_OK;
    count_next  = count;
    if (is_ins && full) begin
      status_next = ST_FULL;
    end else if (is_pop && empty) begin
      status_next = ST_EMPTY;
    end
    if (ctl.ins) begin
      count_next = count + 1'b1;
    end else if (ctl.pop) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // row of cells
  tocq_entry_t              ent      [QUEUE_DEPTH];
  tocq_entry_t              ent_next [QUEUE_DEPTH];
  logic [PAYLOAD_WIDTH-1:0] pl       [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0]     ins_seen;
  logic [QUEUE_DEPTH-1:0]   vld;

  assign ins_seen[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    tocq_entry_t              l_ent;
    tocq_entry_t              r_ent;
    logic [PAYLOAD_WIDTH-1:0] l_pl;
    logic [PAYLOAD_WIDTH-1:0] r_pl;

    if (i == 0) begin : g_head
      assign l_ent = '0;
      assign l_pl  = '0;
    end else begin : g_mid_l
      assign l_ent = ent[i-1];
      assign l_pl  = pl[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_ent = '0;
      assign r_pl  = '0;
    end else begin : g_mid_r
      assign r_ent = ent[i+1];
      assign r_pl  = pl[i+1];
    end

    tocq_cell #(
      .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .new_pl    (new_pl),
      .left_ent  (l_ent),
      .left_pl   (l_pl),
      .right_ent (r_ent),
      .right_pl  (r_pl),
      .before_in (ins_seen[i]),
      .before_out(ins_seen[i+1]),
      .ent       (ent[i]),
      .pl        (pl[i]),
      .ent_next  (ent_next[i])
    );

    assign vld[i] = ent[i].valid;
  end

  // result fields
  logic [ID_W-1:0]   pop_id;
  logic [TKEY_W-1:0] pop_tkey;
  logic [31:0]       pop_pl;
  logic [PAYLOAD_WIDTH+31:0] head_pl_ext;
  logic [ID_W-1:0]   head_id;
  logic [CNT_W+OCC_W-1:0] occ_ext;
  logic [OCC_W-1:0]  occ;

  assign head_pl_ext = {32'd0, pl[0]};
  assign pop_id      = ctl.pop ? ent[0].id : '0;
  assign pop_tkey    = ctl.pop ? ent[0].tkey : '0;
  assign pop_pl      = ctl.pop ? head_pl_ext[31:0] : 32'd0;
  assign head_id     = ent_next[0].valid ? ent_next[0].id : '0;
  assign occ_ext     = {{OCC_W{1'b0}}, count_next};
  assign occ         = occ_ext[OCC_W-1:0];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tuser <= status_next;
      m_axis_tdata <= {2'b00, occ, head_id, ent_next[0].valid, pop_pl, pop_tkey, pop_id};
    end
  end

  // checks
  logic [QUEUE_DEPTH:0] vld_ext;
  assign vld_ext = {1'b0, vld};

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    CNT_W'($countones(vld)) == count)
    else $error("entry count differs from number of valid cells");

  a_vld_packed: assert property (@(posedge clk) disable iff (rst)
    $onehot(vld_ext + 1'b1))
    else $error("valid cells not packed at the head");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    accept && is_ins && full |=> count == DEPTH_C)
    else $error("insert into full queue changed occupancy");

endmodule
